// ----- hdl/pskmd_pkg.sv -----
// Shared types and constants for the PSK mapper and demapper.
`default_nettype none

package pskmd_pkg;

  // Widths fixed by the word format.
  localparam int COORD_W   = 16;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int COUNT_W   = 4;
  localparam int NUM_PAIRS = 4;
  localparam int LANES     = 8;
  localparam int MIN_POINTS = 4;

  typedef enum logic {
    OP_MODULATE   = 1'b0,
    OP_DEMODULATE = 1'b1
  } op_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_PAIR_01 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_PAIR_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_PAIR_45 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_PAIR_67 = 3'd4;

endpackage

`default_nettype wire

// ----- hdl/psk_constellation_mapper_demapper.sv -----
// Top level of the PSK mapper and hard-decision minimum-distance demapper.
`default_nettype none

// Maps a symbol index to a stored constellation point, or finds the stored point nearest
// to an I/Q sample by squared Euclidean distance (lowest index wins a tie). The block
// takes one word per cycle while the pipeline is not held and registers it through six
// register stages: input and differences, squares, distance sums, and three levels of a
// pairwise minimum tree over the eight lanes. The whole pipeline advances together and
// holds while out_valid is high and out_ready is low, so in_ready follows out_ready then.
// Configuration writes are always ready and take effect on the next cycle.
module psk_constellation_mapper_demapper #(
  parameter int COORD_BITS = 16,
  parameter int MAX_POINTS = 8
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire                                     operation,
  input  wire  [pskmd_pkg::IDX_W-1:0]             symbol_index,
  input  wire  signed [pskmd_pkg::COORD_W-1:0]    sample_i,
  input  wire  signed [pskmd_pkg::COORD_W-1:0]    sample_q,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic signed [pskmd_pkg::COORD_W-1:0]    point_i,
  output logic signed [pskmd_pkg::COORD_W-1:0]    point_q,
  output logic [pskmd_pkg::IDX_W-1:0]             decided_index,
  input  wire                                     cfg_valid,
  output logic                                    cfg_ready,
  input  wire  [pskmd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [pskmd_pkg::CFG_W-1:0]             cfg_data
);

  import pskmd_pkg::*;

  localparam int CW     = (COORD_BITS > COORD_W) ? COORD_W : COORD_BITS;
  localparam int DIFF_W = CW + 1;
  localparam int SQ_W   = 2 * CW;
  localparam int DIST_W = SQ_W + 1;
  localparam int PROD_W = 2 * DIFF_W;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] dist_sq;
  } cand_t;

  typedef struct packed {
    logic                      op;
    logic [IDX_W-1:0]          sym;
    logic signed [COORD_W-1:0] pi;
    logic signed [COORD_W-1:0] pq;
  } carry_t;

  // Configuration registers.
  logic [COUNT_W-1:0]           points_in_use;
  logic [NUM_PAIRS-1:0][CFG_W-1:0] point_pair;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= COUNT_W'(LANES);
      point_pair    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POINTS_IN_USE: points_in_use <= cfg_data[COUNT_W-1:0];
        REG_POINT_PAIR_01: point_pair[0] <= cfg_data;
        REG_POINT_PAIR_23: point_pair[1] <= cfg_data;
        REG_POINT_PAIR_45: point_pair[2] <= cfg_data;
        REG_POINT_PAIR_67: point_pair[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective point count, clamped to the range from four to MAX_POINTS.
  logic [COUNT_W-1:0] count_eff;
  always_comb begin
    if (points_in_use < COUNT_W'(MIN_POINTS)) begin
      count_eff = COUNT_W'(MIN_POINTS);
    end else if (points_in_use > COUNT_W'(MAX_POINTS)) begin
      count_eff = COUNT_W'(MAX_POINTS);
    end else begin
      count_eff = points_in_use;
    end
  end

  // One enable for the whole pipeline: it moves unless the output word is stalled.
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // Stage 1: sample differences against every lane and the modulate lookup.
  logic signed [CW-1:0]     pt_i_c [LANES];
  logic signed [CW-1:0]     pt_q_c [LANES];
  logic signed [CW-1:0]     smp_i_c;
  logic signed [CW-1:0]     smp_q_c;
  logic [LANES-1:0]         in_use_c;
  logic [CFG_W-1:0]         mod_pair_c;
  logic [2*COORD_W-1:0]     mod_pt_c;
  logic signed [CW-1:0]     mod_i_c;
  logic signed [CW-1:0]     mod_q_c;
  carry_t                   carry_c;

  always_comb begin
    smp_i_c = sample_i[CW-1:0];
    smp_q_c = sample_q[CW-1:0];
    for (int k = 0; k < LANES; k++) begin
      pt_i_c[k]   = point_pair[k/2][(k%2)*32 +: CW];
      pt_q_c[k]   = point_pair[k/2][(k%2)*32 + COORD_W +: CW];
      in_use_c[k] = (COUNT_W'(k) < count_eff);
    end
    mod_pair_c = point_pair[symbol_index[IDX_W-1:1]];
    mod_pt_c   = symbol_index[0] ? mod_pair_c[CFG_W-1:2*COORD_W]
                                 : mod_pair_c[2*COORD_W-1:0];
    mod_i_c    = mod_pt_c[CW-1:0];
    mod_q_c    = mod_pt_c[COORD_W +: CW];
    carry_c.op  = operation;
    carry_c.sym = symbol_index;
    if (operation == OP_MODULATE && {1'b0, symbol_index} < count_eff) begin
      carry_c.pi = COORD_W'(mod_i_c);
      carry_c.pq = COORD_W'(mod_q_c);
    end else begin
      carry_c.pi = '0;
      carry_c.pq = '0;
    end
  end

  logic                     s1_vld;
  carry_t                   s1_carry;
  logic [LANES-1:0]         s1_use;
  logic signed [DIFF_W-1:0] s1_di [LANES];
  logic signed [DIFF_W-1:0] s1_dq [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (advance) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_carry <= carry_c;
      s1_use   <= in_use_c;
      for (int k = 0; k < LANES; k++) begin
        s1_di[k] <= DIFF_W'(smp_i_c) - DIFF_W'(pt_i_c[k]);
        s1_dq[k] <= DIFF_W'(smp_q_c) - DIFF_W'(pt_q_c[k]);
      end
    end
  end

  // Stage 2: squares. Each is below 2**(2*CW), so the low SQ_W bits are exact.
  logic signed [PROD_W-1:0] prod_i_c [LANES];
  logic signed [PROD_W-1:0] prod_q_c [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      prod_i_c[k] = s1_di[k] * s1_di[k];
      prod_q_c[k] = s1_dq[k] * s1_dq[k];
    end
  end

  logic             s2_vld;
  carry_t           s2_carry;
  logic [LANES-1:0] s2_use;
  logic [SQ_W-1:0]  s2_sqi [LANES];
  logic [SQ_W-1:0]  s2_sqq [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (advance) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_carry <= s1_carry;
      s2_use   <= s1_use;
      for (int k = 0; k < LANES; k++) begin
        s2_sqi[k] <= prod_i_c[k][SQ_W-1:0];
        s2_sqq[k] <= prod_q_c[k][SQ_W-1:0];
      end
    end
  end

  // Stage 3: distance per lane, tagged with its index and whether it is searched.
  logic   s3_vld;
  carry_t s3_carry;
  cand_t  s3_cand [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (advance) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_carry <= s2_carry;
      for (int k = 0; k < LANES; k++) begin
        s3_cand[k].vld     <= s2_use[k];
        s3_cand[k].idx     <= IDX_W'(k);
        s3_cand[k].dist_sq <= DIST_W'(s2_sqi[k]) + DIST_W'(s2_sqq[k]);
      end
    end
  end

  // The lower-index candidate is always the first argument, so it keeps ties.
  function automatic cand_t pick_near(input cand_t lo, input cand_t hi);
    cand_t r;
    if (hi.vld && (!lo.vld || hi.dist_sq < lo.dist_sq)) begin
      r = hi;
    end else begin
      r = lo;
    end
    return r;
  endfunction

  // Stages 4 and 5: first two levels of the minimum tree.
  logic   s4_vld;
  carry_t s4_carry;
  cand_t  s4_cand [LANES/2];
  logic   s5_vld;
  carry_t s5_carry;
  cand_t  s5_cand [LANES/4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else if (advance) begin
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_carry <= s3_carry;
      for (int k = 0; k < LANES/2; k++) begin
        s4_cand[k] <= pick_near(s3_cand[2*k], s3_cand[2*k+1]);
      end
      s5_carry <= s4_carry;
      for (int k = 0; k < LANES/4; k++) begin
        s5_cand[k] <= pick_near(s4_cand[2*k], s4_cand[2*k+1]);
      end
    end
  end

  // Stage 6: final decision into the output word.
  cand_t best_c;
  assign best_c = pick_near(s5_cand[0], s5_cand[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      point_i       <= s5_carry.pi;
      point_q       <= s5_carry.pq;
      decided_index <= (s5_carry.op == OP_DEMODULATE) ? best_c.idx : s5_carry.sym;
    end
  end

endmodule

`default_nettype wire
